/* rtl/running_min_max_mean_tracker_unit_assert.svh */
// Assertion macros used by the tracker top-level RTL.
`ifndef RUNNING_MIN_MAX_MEAN_TRACKER_UNIT_ASSERT_SVH
`define RUNNING_MIN_MAX_MEAN_TRACKER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is low.
`define RMMT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, active in every cycle including reset.
`define RMMT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMMT_ASSERT(label, clk, rst_n, prop, msg)
`define RMMT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* rtl/rmmt_pkg.sv */
// Shared widths, codes and types of the running min/max/mean tracker.
package rmmt_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 32;
    localparam int FRAC_BITS = 8;
    localparam int SUM_W     = SAMPLE_W + COUNT_W;
    localparam int MEAN_W    = SAMPLE_W + FRAC_BITS;
    localparam int DVD_W     = SUM_W + FRAC_BITS;
    localparam int DIV_ITERS = MEAN_W;
    localparam int ITER_W    = $clog2(DIV_ITERS);
    localparam int OP_W      = 2;

    localparam int S_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int RESULT_W   = 2 * SAMPLE_W + COUNT_W + MEAN_W;
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // Item kinds carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_LOAD  = 2'd2
    } t_opcode;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
    } t_dp_stat;

    // Result beat, first field in the high bits
    typedef struct packed {
        logic signed [MEAN_W-1:0]   mean_value;
        logic        [COUNT_W-1:0]  sample_count;
        logic signed [SAMPLE_W-1:0] max_value;
        logic signed [SAMPLE_W-1:0] min_value;
    } t_result;

endpackage

/* rtl/running_min_max_mean_tracker_unit.sv */
// An accepted item passes through the LOAD, DIVIDE and DONE states before its
// result beat is loaded; a new item is accepted only in IDLE. The mean comes from
// the 24 iterations of a radix-2 divider (one quotient bit per cycle).
// A waiting result does not block acceptance of the next item.
// Reset (synchronous, active low) zeroes min, max, count and sum and drops
// the output valid.
`include "running_min_max_mean_tracker_unit_assert.svh"

module running_min_max_mean_tracker_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [15:0] value
    input  logic [rmmt_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [1:0] opcode
    input  logic [rmmt_pkg::OP_W-1:0]        i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [15:0] min_value, [31:16] max_value, [63:32] sample_count,
    // [87:64] mean_value
    output logic [rmmt_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import rmmt_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_result  w_result;

    rmmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    rmmt_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_opcode (i_s_tuser),
        .i_value  (i_s_tdata[SAMPLE_W-1:0]),
        .o_result (w_result)
    );

    assign o_m_tdata = M_TDATA_W'(w_result);

    // One item at a time: no new accept in the cycle after an accept
    `RMMT_ASSERT(a_single_item, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "accept right after accept")
    // Empty statistics report a zero mean
    `RMMT_ASSERT(a_empty_mean, i_clk, i_rst_n, (o_m_tvalid && (w_result.sample_count == '0)) |-> (w_result.mean_value == '0), "nonzero mean with zero count")
    // Minimum never exceeds maximum
    `RMMT_ASSERT(a_min_le_max, i_clk, i_rst_n, o_m_tvalid |-> (w_result.min_value <= w_result.max_value), "min above max")
    // A new result only follows a finished division
    `RMMT_ASSERT(a_load_after_div, i_clk, i_rst_n, w_cmd.out_load |-> $past(w_cmd.div_step) || $past(w_cmd.out_load == 1'b0 && w_cmd.div_step == 1'b0), "result without division")

endmodule

/* rtl/rmmt_ctrl.sv */
// Sequencer: accept, divider load, divide iterations, result hand-off.
module rmmt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output rmmt_pkg::t_dp_cmd  o_cmd,
    input  rmmt_pkg::t_dp_stat i_stat
);
    import rmmt_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    // Commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.div_load = (r_state == S_LOAD);
        o_cmd.div_step = (r_state == S_DIVIDE);
        o_cmd.out_load = (r_state == S_DONE) && out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_LOAD;
            S_LOAD:   n_state = S_DIVIDE;
            S_DIVIDE: if (i_stat.div_last) n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Output beat valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/rmmt_dp.sv */
// Datapath: statistics registers, radix-2 restoring divider, result register.
module rmmt_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rmmt_pkg::t_dp_cmd               i_cmd,
    output rmmt_pkg::t_dp_stat              o_stat,
    input  logic [rmmt_pkg::OP_W-1:0]       i_opcode,
    input  logic [rmmt_pkg::SAMPLE_W-1:0]   i_value,
    output rmmt_pkg::t_result               o_result
);
    import rmmt_pkg::*;

    logic signed [SAMPLE_W-1:0] r_min, r_max;
    logic        [COUNT_W-1:0]  r_count;
    logic signed [SUM_W-1:0]    r_sum;

    logic                       r_neg, r_zero;
    logic        [COUNT_W-1:0]  r_rem;
    logic        [MEAN_W-1:0]   r_quo;
    logic        [ITER_W-1:0]   r_iter;
    t_result                    r_result;

    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SUM_W-1:0]    sample_ext;
    logic        [SUM_W-1:0]    mag;
    logic        [DVD_W-1:0]    dividend;
    logic        [COUNT_W:0]    trial;
    logic        [COUNT_W-1:0]  n_rem;
    logic                       q_bit;
    logic        [MEAN_W-1:0]   mean_bits;

    assign sample     = i_value;
    assign sample_ext = {{(SUM_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};

    // Statistics update on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '0;
            r_max   <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.accept) begin
            case (t_opcode'(i_opcode))
                OP_ADD: begin
                    if (sample > r_max) r_max <= sample;
                    if (sample < r_min) r_min <= sample;
                    // count and sum hold once the count saturates
                    if (r_count != {COUNT_W{1'b1}}) begin
                        r_count <= r_count + COUNT_W'(1);
                        r_sum   <= r_sum + sample_ext;
                    end
                end
                OP_CLEAR: begin
                    r_min   <= '0;
                    r_max   <= '0;
                    r_count <= '0;
                    r_sum   <= '0;
                end
                OP_LOAD: begin
                    r_min <= sample;
                    r_max <= sample;
                end
                default: ;
            endcase
        end
    end

    // Divider operands: |sum| scaled by the fraction bits over the count.
    // The quotient fits MEAN_W bits, so the top COUNT_W dividend bits start
    // below the divisor and only MEAN_W iterations are needed.
    assign mag      = r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
    assign dividend = DVD_W'(mag) << FRAC_BITS;

    // One restoring step
    assign trial = {r_rem, r_quo[MEAN_W-1]} - {1'b0, r_count};
    assign q_bit = !trial[COUNT_W];
    assign n_rem = q_bit ? trial[COUNT_W-1:0] : {r_rem[COUNT_W-2:0], r_quo[MEAN_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_neg  <= r_sum[SUM_W-1];
            r_zero <= (r_count == '0);
            r_rem  <= dividend[DVD_W-1 -: COUNT_W];
            r_quo  <= dividend[MEAN_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_quo  <= {r_quo[MEAN_W-2:0], q_bit};
        end
    end

    // Iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
        end else if (i_cmd.div_load) begin
            r_iter <= '0;
        end else if (i_cmd.div_step) begin
            r_iter <= r_iter + ITER_W'(1);
        end
    end

    assign o_stat.div_last = (r_iter == ITER_W'(DIV_ITERS - 1));

    // Sign restore, empty set reads zero
    assign mean_bits = r_zero ? '0 : (r_neg ? (MEAN_W'(0) - r_quo) : r_quo);

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result.min_value    <= r_min;
            r_result.max_value    <= r_max;
            r_result.sample_count <= r_count;
            r_result.mean_value   <= mean_bits;
        end
    end

    assign o_result = r_result;

endmodule
